// ----- sv/chtr_pkg.sv -----
`default_nettype none

package chtr_pkg;

  // Number of controller ports held in the sample store (1 to 8)
  localparam int PORTS = 4;
  localparam int PORT_W = (PORTS > 1) ? $clog2(PORTS) : 1;

  // FNV-1a 64 constants; the prime is 2^40 + 0x1b3
  localparam logic [63:0] HASH_BASIS   = 64'hCBF2_9CE4_8422_2325;
  localparam int          PRIME_SHIFT  = 40;
  localparam logic [8:0]  PRIME_LOW    = 9'h1B3;
  localparam logic [31:0] PERTURB_WORD = 32'h494E_5054;

  // Item opcodes
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_TRACE_ENABLE   = 2'd0;
  localparam logic [1:0] REG_PERTURB_ENABLE = 2'd1;
  localparam logic [1:0] REG_PERTURB_TICK   = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_PORT,
    S_PERTURB,
    S_COUNT,
    S_DONE
  } state_t;

  // Order in which one port's sample words enter the hash
  typedef enum logic [2:0] {
    F_HELD,
    F_PRESSED,
    F_RELEASED,
    F_HORIZ,
    F_VERT,
    F_CONN
  } field_t;

  // One port's stored sample
  typedef struct packed {
    logic [15:0] held;
    logic [15:0] pressed;
    logic [15:0] released;
    logic [7:0]  horiz;
    logic [7:0]  vert;
    logic        connected;
  } sample_t;

  // Set-bit count of a 16-bit mask, as a small adder tree over nibbles
  function automatic logic [4:0] ones16(input logic [15:0] v);
    logic [2:0] nib [4];
    logic [4:0] total;
    for (int i = 0; i < 4; i++) begin
      nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
    end
    total = (5'(nib[0]) + 5'(nib[1])) + (5'(nib[2]) + 5'(nib[3]));
    return total;
  endfunction

endpackage

`default_nettype wire

// ----- sv/controller_state_hash_tracer_core.sv -----
`default_nettype none

// Controller state hash tracer.
// Items arrive on the item channel (item_valid / item_stall) and results leave
// on the result channel (result_valid / result_stall); a beat moves when valid
// is high and stall is low. With tracing on, an observe beat stores one port's
// sample and a tick beat runs FNV-1a 64 over the tick and every stored sample,
// one byte per cycle through a single shared round unit: 4 * (2 + 6 * PORTS)
// bytes, plus 4 when the perturb word is mixed in, then the counters update
// and the result register loads; item_stall stays high from the tick's accept
// until then. The user must write configuration through write_enable,
// reg_index and write_data only while the block is idle; the block does not
// enforce this. Reset clears the sample store, counters, configuration and
// result_valid, not the result data. If the receiver stalls, the result
// register holds; observe beats are still taken while idle, and a finished
// tick waits until the held result has been taken before loading its own.

module controller_state_hash_tracer_core
  import chtr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               write_enable,
  input  wire logic [1:0]         reg_index,
  input  wire logic [62:0]        write_data,
  // item channel
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic               opcode,
  input  wire logic [2:0]         port,
  input  wire logic [15:0]        held_mask,
  input  wire logic [15:0]        pressed_mask,
  input  wire logic [15:0]        released_mask,
  input  wire logic signed [7:0]  stick_horiz,
  input  wire logic signed [7:0]  stick_vert,
  input  wire logic               connected,
  input  wire logic [63:0]        tick_number,
  // result channel
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [63:0]             frame_hash,
  output logic [63:0]             tick_total,
  output logic [63:0]             active_total,
  output logic [63:0]             press_total,
  output logic [63:0]             release_total,
  output logic [63:0]             presence_change_total
);

  state_t state, state_next;

  logic              trace_enable;
  logic              perturb_enable;
  logic [62:0]       perturb_tick;

  logic              accept;
  logic              store_we;
  logic              tick_start;
  logic              out_free;

  logic [63:0]       tick_value;
  logic              perturb_hit;
  logic              half;
  logic [1:0]        byte_idx;
  logic [PORT_W-1:0] port_idx;
  field_t            field;
  logic              last_byte;
  logic              last_port;

  logic [PORTS-1:0]  presence;
  logic [PORTS-1:0]  prior_presence;
  logic              prior_presence_valid;
  logic              active;

  logic [63:0]       tick_count;
  logic [63:0]       active_count;
  logic [63:0]       press_count;
  logic [63:0]       release_count;
  logic [63:0]       presence_change_count;

  sample_t           wr_sample;
  sample_t           rd_sample;
  logic              hash_step;
  logic              sample_take;
  logic [31:0]       word;
  logic [63:0]       hash;

  // Handshake
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign store_we   = accept && trace_enable && (opcode == OP_OBSERVE) &&
                      (int'(port) < PORTS);
  assign tick_start = accept && trace_enable && (opcode == OP_TICK);
  assign last_byte  = (byte_idx == 2'd3);
  assign last_port  = (port_idx == PORT_W'(PORTS - 1));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trace_enable   <= 1'b0;
      perturb_enable <= 1'b0;
      perturb_tick   <= '0;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_TRACE_ENABLE:   trace_enable   <= write_data[0];
        REG_PERTURB_ENABLE: perturb_enable <= write_data[0];
        REG_PERTURB_TICK:   perturb_tick   <= write_data;
        default: ;
      endcase
    end
  end

  // Sample store
  assign wr_sample = '{held:      held_mask,
                       pressed:   pressed_mask,
                       released:  released_mask,
                       horiz:     $unsigned(stick_horiz),
                       vert:      $unsigned(stick_vert),
                       connected: connected};

  chtr_sample_store u_store (
    .clk       (clk),
    .rst       (rst),
    .we        (store_we),
    .wr_index  (port[PORT_W-1:0]),
    .wr_sample (wr_sample),
    .rd_index  (port_idx),
    .rd_sample (rd_sample)
  );

  // Shared FNV round unit
  chtr_hash_unit u_hash (
    .clk       (clk),
    .load      (tick_start),
    .step      (hash_step),
    .data_byte (word[8*byte_idx +: 8]),
    .hash      (hash)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (tick_start) state_next = S_TICK;
      end
      S_TICK: begin
        if (half && last_byte) state_next = S_PORT;
      end
      S_PORT: begin
        if (last_port && (field == F_CONN) && last_byte) begin
          state_next = perturb_hit ? S_PERTURB : S_COUNT;
        end
      end
      S_PERTURB: begin
        if (last_byte) state_next = S_COUNT;
      end
      S_COUNT: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: word to hash and sample pickup strobe
  always_comb begin
    hash_step   = 1'b0;
    sample_take = 1'b0;
    word        = '0;
    unique case (state)
      S_TICK: begin
        hash_step = 1'b1;
        word      = half ? tick_value[63:32] : tick_value[31:0];
      end
      S_PORT: begin
        hash_step   = 1'b1;
        sample_take = (field == F_HELD) && (byte_idx == 2'd0);
        case (field)
          F_HELD:     word = {16'd0, rd_sample.held};
          F_PRESSED:  word = {16'd0, rd_sample.pressed};
          F_RELEASED: word = {16'd0, rd_sample.released};
          F_HORIZ:    word = {24'd0, rd_sample.horiz};
          F_VERT:     word = {24'd0, rd_sample.vert};
          F_CONN:     word = {31'd0, rd_sample.connected};
          default:    word = '0;
        endcase
      end
      S_PERTURB: begin
        hash_step = 1'b1;
        word      = PERTURB_WORD;
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Byte, half, field and port counters
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= '0;
      half     <= 1'b0;
      port_idx <= '0;
      field    <= F_HELD;
    end else if (tick_start) begin
      byte_idx <= '0;
      half     <= 1'b0;
      port_idx <= '0;
      field    <= F_HELD;
    end else if (hash_step) begin
      byte_idx <= byte_idx + 2'd1;
      if (last_byte) begin
        if (state == S_TICK) begin
          half <= 1'b1;
        end
        if (state == S_PORT) begin
          if (field == F_CONN) begin
            field <= F_HELD;
            if (!last_port) port_idx <= port_idx + PORT_W'(1);
          end else begin
            field <= field_t'(field + 3'd1);
          end
        end
      end
    end
  end

  // Tick value and perturb match, taken when the tick beat is accepted
  always_ff @(posedge clk) begin
    if (tick_start) begin
      tick_value  <= tick_number;
      perturb_hit <= perturb_enable && (tick_number == {1'b0, perturb_tick});
    end
  end

  // Running counters, one port per sample pickup, totals after the hash
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count            <= '0;
      active_count          <= '0;
      press_count           <= '0;
      release_count         <= '0;
      presence_change_count <= '0;
      prior_presence        <= '0;
      prior_presence_valid  <= 1'b0;
      presence              <= '0;
      active                <= 1'b0;
    end else if (tick_start) begin
      presence <= '0;
      active   <= 1'b0;
    end else if (sample_take) begin
      press_count        <= press_count + 64'(ones16(rd_sample.pressed));
      release_count      <= release_count + 64'(ones16(rd_sample.released));
      presence[port_idx] <= rd_sample.connected;
      if ((|rd_sample.held) || (|rd_sample.pressed) || (|rd_sample.released) ||
          (|rd_sample.horiz) || (|rd_sample.vert)) begin
        active <= 1'b1;
      end
    end else if (state == S_COUNT) begin
      tick_count           <= tick_count + 64'd1;
      active_count         <= active_count + 64'(active);
      prior_presence       <= presence;
      prior_presence_valid <= 1'b1;
      if (prior_presence_valid && (presence != prior_presence)) begin
        presence_change_count <= presence_change_count + 64'd1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      frame_hash            <= hash;
      tick_total            <= tick_count;
      active_total          <= active_count;
      press_total           <= press_count;
      release_total         <= release_count;
      presence_change_total <= presence_change_count;
    end
  end

  // Checks
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done step");

  a_result_snapshot: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=>
      (tick_total == tick_count) && (press_total == press_count) &&
      (frame_hash == $past(hash)))
    else $error("result register does not match counters");

  a_no_store_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !store_we)
    else $error("sample store written during a tick");

  a_byte_aligned_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_COUNT) |-> (byte_idx == 2'd0) && (field == F_HELD))
    else $error("hash sequence ended mid word");

endmodule

`default_nettype wire

// ----- sv/chtr_sample_store.sv -----
`default_nettype none

module chtr_sample_store
  import chtr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [PORT_W-1:0] wr_index,
  input  wire sample_t           wr_sample,
  input  wire logic [PORT_W-1:0] rd_index,
  output sample_t                rd_sample
);

  sample_t samples [PORTS];

  // Per-port sample registers, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PORTS; p++) begin
        samples[p] <= '0;
      end
    end else if (we) begin
      samples[wr_index] <= wr_sample;
    end
  end

  // Single read port used by the hash sequencer
  assign rd_sample = samples[rd_index];

endmodule

`default_nettype wire

// ----- sv/chtr_hash_unit.sv -----
`default_nettype none

module chtr_hash_unit
  import chtr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  output logic      [63:0] hash
);

  logic [63:0] mixed;
  logic [63:0] low_prod;
  logic [63:0] hash_next;

  // One FNV-1a round: xor the byte, then multiply by 2^40 + 0x1b3
  assign mixed     = hash ^ {56'd0, data_byte};
  assign low_prod  = mixed * 64'(PRIME_LOW);
  assign hash_next = (mixed << PRIME_SHIFT) + low_prod;

  always_ff @(posedge clk) begin
    if (load) begin
      hash <= HASH_BASIS;
    end else if (step) begin
      hash <= hash_next;
    end
  end

endmodule

`default_nettype wire
